// ===== rtl/core/pee_pkg.sv =====
// Shared constants, types and helpers for the postfix expression evaluator.
package pee_pkg;

   localparam int PEE_STACK_DEPTH = 64;
   localparam int PEE_VALUE_WIDTH = 32;

   localparam int CHAR_W      = 8;
   localparam int RSP_VALUE_W = 32;
   localparam int STATUS_W    = 3;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } alu_mode_type;

   typedef struct packed {
      logic         start;
      alu_mode_type mode;
   } alu_ctl_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // First error wins
   function automatic logic [STATUS_W-1:0] note_error(input logic [STATUS_W-1:0] cur,
                                                      input logic [STATUS_W-1:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   function automatic alu_mode_type op_mode(input logic [CHAR_W-1:0] c);
      alu_mode_type m;
      case (c)
         CH_PLUS:  m = MODE_ADD;
         CH_MINUS: m = MODE_SUB;
         CH_STAR:  m = MODE_MUL;
         default:  m = MODE_DIV;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/pee_if.sv =====
// Request and response channel interfaces (valid/ready).
interface pee_req_if import pee_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;

   modport source (output valid, char_code, is_last, input ready);
   modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface pee_rsp_if import pee_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [RSP_VALUE_W-1:0] value;
   logic [STATUS_W-1:0]           status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

// ===== rtl/core/postfix_expression_evaluator.sv =====
// Postfix expression evaluator: top level with stack memory and sequencer.
//
// Usage:
//   req_ch carries one expression character per transfer (char_code) and
//   is_last, which marks the final character. A digit pushes its value; any
//   other character pops b then a and, for + - * /, pushes a op b.
//   rsp_ch carries one result per expression (value, status) after the
//   character marked last. Status: 0 ok, 1 missing operand, 2 divide by
//   zero, 3 stack full, 4 empty at end; value is 0 unless status is ok.
// Timing:
//   A digit is written to the stack on the transfer edge. + and - do two
//   stack reads, then one add or subtract in the shared ALU; * and / do
//   two stack reads, then the shared ALU running one bit per cycle. A
//   last character then passes S_TOP to read the top of stack and S_OUT
//   to load the response register.
//   req_ch.ready is high only while the sequencer is idle.
// Stall:
//   The response sits in an output register; characters of the next
//   expression are taken while it waits. A next last character holds in
//   the final state until the response register is free.
// Reset:
//   Synchronous, active high. Clears the sequencer, stack count, sticky
//   error and response valid. The stack memory is not cleared.
module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH = PEE_STACK_DEPTH,
   parameter int VALUE_WIDTH = PEE_VALUE_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   pee_req_if.sink   req_ch,
   pee_rsp_if.source rsp_ch
);

   localparam int VW = VALUE_WIDTH;
   localparam int CW = $clog2(STACK_DEPTH + 1);   // count, holds the depth itself
   localparam int IW = $clog2(STACK_DEPTH);       // stack index
   localparam int XW = (VW > RSP_VALUE_W) ? VW : RSP_VALUE_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,   // waiting for a character
      S_RD_B = 6'b000010,   // top operand on the read port
      S_RD_A = 6'b000100,   // second operand on the read port, dispatch
      S_EXEC = 6'b001000,   // ALU running
      S_TOP  = 6'b010000,   // read top of stack for the response
      S_OUT  = 6'b100000    // load response register
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [STATUS_W-1:0]     err_ff, err_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic                    last_ff, last_in;
   logic [VW-1:0]           b_ff, b_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // operand stack
   logic [VW-1:0]           stack_mem [STACK_DEPTH];
   logic [VW-1:0]           rd_data_ff;
   logic [IW-1:0]           rd_addr;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic [VW-1:0]           wr_data;

   alu_ctl_type             alu_ctl;
   logic                    alu_done;
   logic [VW-1:0]           alu_result;

   logic                    req_xfer;
   logic                    rsp_free;
   logic [CW-1:0]           cnt_m1, cnt_m2;
   logic [XW-1:0]           top_ext;
   state_type               after_op;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign cnt_m1       = count_ff - CW'(1);
   assign cnt_m2       = count_ff - CW'(2);
   assign top_ext      = XW'(rd_data_ff);      // low 32 bits, zero-extended if narrow
   assign after_op     = last_ff ? S_TOP : S_IDLE;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = cnt_m1[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[IW-1:0];
      wr_data       = '0;
      alu_ctl       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               char_in = req_ch.char_code;
               last_in = req_ch.is_last;
               if (is_digit(req_ch.char_code)) begin
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     err_in = note_error(err_ff, ST_FULL);
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = VW'(req_ch.char_code - CH_ZERO);
                     count_in = count_ff + CW'(1);
                  end
                  state_in = req_ch.is_last ? S_TOP : S_IDLE;
               end else if (count_ff < CW'(2)) begin
                  // operator short of operands: empty the stack
                  count_in = '0;
                  err_in   = note_error(err_ff, ST_MISSING);
                  state_in = req_ch.is_last ? S_TOP : S_IDLE;
               end else begin
                  state_in = S_RD_B;          // read of b issued this cycle
               end
            end
         end
         S_RD_B: begin
            b_in     = rd_data_ff;
            rd_addr  = cnt_m2[IW-1:0];
            state_in = S_RD_A;
         end
         S_RD_A: begin
            if (char_ff == CH_SLASH && b_ff == '0) begin
               err_in   = note_error(err_ff, ST_DIVZERO);
               count_in = cnt_m2;
               state_in = after_op;
            end else if (char_ff inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
               alu_ctl.start = 1'b1;
               alu_ctl.mode  = op_mode(char_ff);
               state_in      = S_EXEC;
            end else begin
               // unknown operator just drops both operands
               count_in = cnt_m2;
               state_in = after_op;
            end
         end
         S_EXEC: begin
            if (alu_done) begin
               // two popped, one pushed: never overflows
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[IW-1:0];
               wr_data  = alu_result;
               count_in = cnt_m1;
               state_in = after_op;
            end
         end
         S_TOP: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
                  rsp_value_in  = '0;
               end else if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_value_in  = top_ext[RSP_VALUE_W-1:0];
               end
               count_in = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      last_ff       <= last_in;
      b_ff          <= b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem[rd_addr];
   end

   pee_alu #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (rd_data_ff),
      .opb    (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

// ===== rtl/core/pee_alu.sv =====
// Iterative add/sub/multiply/divide unit built around one shared adder.
module pee_alu import pee_pkg::*; #(
   parameter int VALUE_WIDTH = PEE_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  alu_ctl_type            ctl,
   input  logic [VALUE_WIDTH-1:0] opa,
   input  logic [VALUE_WIDTH-1:0] opb,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int VW = VALUE_WIDTH;
   localparam int NW = $clog2(VW + 1);

   alu_mode_type   mode_ff, mode_in;
   logic [VW-1:0]  acc_ff, acc_in;
   logic [VW-1:0]  shf_ff, shf_in;
   logic [VW-1:0]  opr_ff, opr_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic           neg_ff, neg_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   logic [VW:0]    add_x, add_y, sum;
   logic           sub;
   logic           ge;
   logic [VW-1:0]  mag_a, mag_b;

   assign mag_a = opa[VW-1] ? (~opa + VW'(1)) : opa;
   assign mag_b = opb[VW-1] ? (~opb + VW'(1)) : opb;

   // shared adder; divide uses it as the trial subtract
   always_comb begin
      if (mode_ff == MODE_DIV) begin
         add_x = {acc_ff, shf_ff[VW-1]};
         add_y = {1'b0, opr_ff};
         sub   = 1'b1;
      end else begin
         add_x = {1'b0, acc_ff};
         add_y = {1'b0, shf_ff};
         sub   = (mode_ff == MODE_SUB);
      end
      sum = add_x + (sub ? ~add_y : add_y) + (VW + 1)'(sub);
      ge  = ~sum[VW];
   end

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      shf_in  = shf_ff;
      opr_in  = opr_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         mode_in = ctl.mode;
         busy_in = 1'b1;
         neg_in  = (ctl.mode == MODE_DIV) && (opa[VW-1] ^ opb[VW-1]);
         case (ctl.mode)
            MODE_ADD, MODE_SUB: begin
               acc_in = opa;
               shf_in = opb;
               opr_in = opb;
               cnt_in = NW'(1);
            end
            MODE_MUL: begin
               acc_in = '0;
               shf_in = opa;
               opr_in = opb;
               cnt_in = NW'(VW);
            end
            default: begin
               acc_in = '0;
               shf_in = mag_a;
               opr_in = mag_b;
               cnt_in = NW'(VW);
            end
         endcase
      end else if (busy_ff) begin
         case (mode_ff)
            MODE_ADD, MODE_SUB: acc_in = sum[VW-1:0];
            MODE_MUL: begin
               if (opr_ff[0]) acc_in = sum[VW-1:0];
               shf_in = {shf_ff[VW-2:0], 1'b0};
               opr_in = {1'b0, opr_ff[VW-1:1]};
            end
            default: begin
               acc_in = ge ? sum[VW-1:0] : add_x[VW-1:0];
               shf_in = {shf_ff[VW-2:0], ge};
            end
         endcase
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      acc_ff  <= acc_in;
      shf_ff  <= shf_in;
      opr_ff  <= opr_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   assign done   = done_ff;
   assign result = (mode_ff != MODE_DIV) ? acc_ff :
                   (neg_ff ? (~shf_ff + VW'(1)) : shf_ff);

endmodule

// ===== rtl/core/pee_checker.sv =====
// Port-level assertions for the postfix expression evaluator, with bind.
module pee_checker import pee_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [RSP_VALUE_W-1:0] rsp_value,
   input logic [STATUS_W-1:0]    rsp_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_MISSING ||
                     rsp_status == ST_DIVZERO || rsp_status == ST_FULL ||
                     rsp_status == ST_EMPTY))
      else $error("undefined status code");

   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
      else $error("nonzero value with error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.value),
   .rsp_status (rsp_ch.status)
);
